// ----- design/ellipsoid_distance_lambda_newton_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ellipsoid distance block
// Shared implication forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef ELLIPSOID_DISTANCE_LAMBDA_NEWTON_MACROS_SVH
`define ELLIPSOID_DISTANCE_LAMBDA_NEWTON_MACROS_SVH

// same-cycle implication
`define EDLN_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EDLN_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/edln_pkg.sv -----
// ----------------------------------------------------------------------------
// edln_pkg
// Types and constants for the point-to-ellipsoid distance block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package edln_pkg;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [31:0] closest_x;
        logic signed [31:0] closest_y;
        logic signed [31:0] closest_z;
        logic signed [31:0] signed_distance;
    } result_t;

    localparam logic [2:0] CFG_AXIS_A    = 3'd0;
    localparam logic [2:0] CFG_AXIS_B    = 3'd1;
    localparam logic [2:0] CFG_AXIS_C    = 3'd2;
    localparam logic [2:0] CFG_MAX_ITER  = 3'd3;
    localparam logic [2:0] CFG_TOLERANCE = 3'd4;

    localparam logic [30:0] AXIS_RESET     = 31'd65536;
    localparam logic [5:0]  MAX_ITER_RESET = 6'd40;
    localparam logic [31:0] TOL_RESET      = 32'd1100;

    localparam logic signed [63:0] LAMBDA_START = 64'sd54975581389;
    localparam logic signed [63:0] S64_MAX      = 64'sh7fff_ffff_ffff_ffff;
    localparam logic signed [63:0] S64_MIN      = 64'sh8000_0000_0000_0000;
    localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
    localparam logic [63:0] TERM_CAP = 64'h2000_0000_0000_0000;
    localparam logic [63:0] SCALE_48 = 64'h0001_0000_0000_0000;
    localparam logic [63:0] SCALE_55 = 64'h0080_0000_0000_0000;

    typedef struct packed {
        logic        start;
        logic        mul_only;
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
    } md_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] result;
    } md_rsp_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_CHECK,
        MD_DIV
    } md_state_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A2,
        ST_PA,
        ST_CHECK,
        ST_R,
        ST_G,
        ST_H,
        ST_STEP,
        ST_Y,
        ST_SQ,
        ST_NP,
        ST_NY,
        ST_SQRT,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

// ----- design/edln_muldiv.sv -----
// ----------------------------------------------------------------------------
// edln_muldiv
// Shared multiply-divide unit: floor(a*b/c) with saturation, or a*b low word.
// Radix-2 multiply, then restoring divide when a quotient is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module edln_muldiv
    import edln_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire md_req_t req,
    output md_rsp_t      rsp
);

    md_state_t   state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] hi_reg, hi_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] c_reg, c_next;
    logic        mul_only_reg, mul_only_next;
    logic [63:0] result_reg, result_next;
    logic        done_reg, done_next;

    logic [64:0] sum65;
    logic        carry;
    logic [63:0] shifted;
    logic        qbit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        a_reg        <= a_next;
        c_reg        <= c_next;
        mul_only_reg <= mul_only_next;
        result_reg   <= result_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        a_next        = a_reg;
        c_next        = c_reg;
        mul_only_next = mul_only_reg;
        result_next   = result_reg;
        done_next     = 1'b0;

        sum65   = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : 65'd0);
        carry   = hi_reg[63];
        shifted = {hi_reg[62:0], lo_reg[63]};
        qbit    = carry || (shifted >= c_reg);

        case (state_reg)
            MD_IDLE:
            begin
                if (req.start)
                begin
                    a_next        = req.a;
                    c_next        = req.c;
                    mul_only_next = req.mul_only;
                    hi_next       = '0;
                    lo_next       = req.b;
                    cnt_next      = '0;
                    state_next    = MD_MUL;
                end
            end
            MD_MUL:
            begin
                hi_next  = sum65[64:1];
                lo_next  = {sum65[0], lo_reg[63:1]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == '1)
                    state_next = MD_CHECK;
            end
            MD_CHECK:
            begin
                if (mul_only_reg)
                begin
                    result_next = lo_reg;
                    done_next   = 1'b1;
                    state_next  = MD_IDLE;
                end
                else if (c_reg == '0)
                begin
                    result_next = ((hi_reg | lo_reg) != '0) ? '1 : '0;
                    done_next   = 1'b1;
                    state_next  = MD_IDLE;
                end
                else if (hi_reg >= c_reg)
                begin
                    result_next = '1;
                    done_next   = 1'b1;
                    state_next  = MD_IDLE;
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                hi_next  = qbit ? shifted - c_reg : shifted;
                lo_next  = {lo_reg[62:0], qbit};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == '1)
                begin
                    result_next = {lo_reg[62:0], qbit};
                    done_next   = 1'b1;
                    state_next  = MD_IDLE;
                end
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    assign rsp.busy   = (state_reg != MD_IDLE);
    assign rsp.done   = done_reg;
    assign rsp.result = result_reg;

endmodule

`default_nettype wire

// ----- design/ellipsoid_distance_lambda_newton.sv -----
// ----------------------------------------------------------------------------
// ellipsoid_distance_lambda_newton
// Nearest point on an axis-aligned ellipsoid and signed distance to it,
// by Newton iteration on the Lagrange multiplier.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+---------------------------
//  in       | input     | in_valid/in_stall  | in_data  (point_t)
//  out      | output    | out_valid/out_stall| out_data (result_t)
//  cfg      | input     | cfg_write          | cfg_index, cfg_data
//
//  One point at a time. Every product and quotient goes through one shared
//  multiply-divide unit. A Newton step is ten divides plus a check state.
//  A point takes at most max_iterations steps, plus any output stall.
//  in_stall is high from acceptance until the result is loaded into the
//  output register; a held result does not block the next point.
//  Reset clears control state and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ellipsoid_distance_lambda_newton_macros.svh"

module ellipsoid_distance_lambda_newton
    import edln_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire point_t      in_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output result_t          out_data,
    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [30:0] axis_a_reg, axis_b_reg, axis_c_reg;
    logic [5:0]  max_iter_reg;
    logic [31:0] tol_reg;

    state_t state_reg, state_next;
    logic [1:0] k_reg, k_next;
    logic       wait_reg, wait_next;
    logic [5:0] it_reg, it_next;

    logic signed [31:0] p_reg [3], p_next [3];
    logic [31:0]        pm_reg [3], pm_next [3];
    logic [61:0]        a2_reg [3], a2_next [3];
    logic [61:0]        pa_reg [3], pa_next [3];
    logic signed [31:0] y_reg [3], y_next [3];

    logic signed [63:0] l0_reg, l0_next;
    logic signed [63:0] l1_reg, l1_next;
    logic [63:0]        r_reg, r_next;
    logic [61:0]        g_reg, g_next;
    logic [63:0]        gsum_reg, gsum_next;
    logic signed [63:0] hsum_reg, hsum_next;
    logic [63:0]        dsum_reg, dsum_next;
    logic [63:0]        np_reg, np_next;
    logic [63:0]        ny_reg, ny_next;
    logic [63:0]        sqv_reg, sqv_next;
    logic [63:0]        sqr_reg, sqr_next;
    logic [4:0]         sqj_reg, sqj_next;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg, out_data_next;

    md_req_t md_req;
    md_rsp_t md_rsp;

    logic [30:0]        ax_k;
    logic signed [63:0] lq;
    logic signed [63:0] d_k;
    logic [63:0]        dm_k;
    logic [63:0]        change;
    logic [63:0]        h_cap;
    logic signed [63:0] f_val;
    logic [63:0]        fm, hm;
    logic signed [63:0] step;
    logic signed [63:0] delta;
    logic signed [63:0] lsum;
    logic               ovf;
    logic [63:0]        ym;
    logic               neg;
    logic signed [32:0] diff;
    logic [32:0]        dmag;
    logic [64:0]        dsum65;
    logic [31:0]        ymag;
    logic [63:0]        bitv;
    logic [63:0]        trial;
    logic [31:0]        dist_sat;

    edln_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_a_reg   <= AXIS_RESET;
            axis_b_reg   <= AXIS_RESET;
            axis_c_reg   <= AXIS_RESET;
            max_iter_reg <= MAX_ITER_RESET;
            tol_reg      <= TOL_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_AXIS_A:    axis_a_reg   <= cfg_data[30:0];
                CFG_AXIS_B:    axis_b_reg   <= cfg_data[30:0];
                CFG_AXIS_C:    axis_c_reg   <= cfg_data[30:0];
                CFG_MAX_ITER:  max_iter_reg <= cfg_data[5:0];
                CFG_TOLERANCE: tol_reg      <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wait_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg        <= k_next;
        it_reg       <= it_next;
        p_reg        <= p_next;
        pm_reg       <= pm_next;
        a2_reg       <= a2_next;
        pa_reg       <= pa_next;
        y_reg        <= y_next;
        l0_reg       <= l0_next;
        l1_reg       <= l1_next;
        r_reg        <= r_next;
        g_reg        <= g_next;
        gsum_reg     <= gsum_next;
        hsum_reg     <= hsum_next;
        dsum_reg     <= dsum_next;
        np_reg       <= np_next;
        ny_reg       <= ny_next;
        sqv_reg      <= sqv_next;
        sqr_reg      <= sqr_next;
        sqj_reg      <= sqj_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        wait_next      = wait_reg;
        it_next        = it_reg;
        p_next         = p_reg;
        pm_next        = pm_reg;
        a2_next        = a2_reg;
        pa_next        = pa_reg;
        y_next         = y_reg;
        l0_next        = l0_reg;
        l1_next        = l1_reg;
        r_next         = r_reg;
        g_next         = g_reg;
        gsum_next      = gsum_reg;
        hsum_next      = hsum_reg;
        dsum_next      = dsum_reg;
        np_next        = np_reg;
        ny_next        = ny_reg;
        sqv_next       = sqv_reg;
        sqr_next       = sqr_reg;
        sqj_next       = sqj_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;

        md_req.start    = 1'b0;
        md_req.mul_only = 1'b0;
        md_req.a        = '0;
        md_req.b        = '0;
        md_req.c        = '0;

        case (k_reg)
            2'd0:    ax_k = axis_a_reg;
            2'd1:    ax_k = axis_b_reg;
            default: ax_k = axis_c_reg;
        endcase

        // lambda in Q24.40 down to Q32.32, floor
        lq   = l0_reg >>> 8;
        d_k  = $signed({2'b00, a2_reg[k_reg]}) + lq;
        dm_k = d_k[63] ? 64'(-d_k) : 64'(d_k);

        change = (l1_reg >= l0_reg) ? 64'(l1_reg - l0_reg) : 64'(l0_reg - l1_reg);

        h_cap = (md_rsp.result > TERM_CAP) ? TERM_CAP : md_rsp.result;

        f_val = $signed(gsum_reg - ONE_Q32);
        fm    = f_val[63] ? 64'(-f_val) : 64'(f_val);
        hm    = hsum_reg[63] ? 64'(-hsum_reg) : 64'(hsum_reg);
        step  = md_rsp.result[63] ? S64_MAX : $signed(md_rsp.result);
        delta = (f_val[63] != hsum_reg[63]) ? -step : step;
        lsum  = l0_reg + delta;
        ovf   = (l0_reg[63] == delta[63]) && (lsum[63] != l0_reg[63]);

        ym   = md_rsp.result;
        neg  = p_reg[k_reg][31] ^ d_k[63];
        diff = {p_reg[k_reg][31], p_reg[k_reg]} - {y_reg[k_reg][31], y_reg[k_reg]};
        dmag = diff[32] ? 33'(-diff) : 33'(diff);
        dsum65 = {1'b0, dsum_reg} + {1'b0, md_rsp.result};
        ymag = y_reg[k_reg][31] ? 32'(-y_reg[k_reg]) : 32'(y_reg[k_reg]);

        bitv     = 64'd1 << {sqj_reg, 1'b0};
        trial    = sqr_reg + bitv;
        dist_sat = (sqr_reg[63:31] != '0) ? 32'h7fff_ffff : sqr_reg[31:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    p_next[0] = in_data.point_x;
                    p_next[1] = in_data.point_y;
                    p_next[2] = in_data.point_z;
                    pm_next[0] = in_data.point_x[31] ? 32'(-in_data.point_x) : in_data.point_x;
                    pm_next[1] = in_data.point_y[31] ? 32'(-in_data.point_y) : in_data.point_y;
                    pm_next[2] = in_data.point_z[31] ? 32'(-in_data.point_z) : in_data.point_z;
                    l0_next    = '0;
                    l1_next    = LAMBDA_START;
                    it_next    = '0;
                    k_next     = '0;
                    state_next = ST_A2;
                end
            end
            ST_A2:
            begin
                md_req.mul_only = 1'b1;
                md_req.a        = {33'd0, ax_k};
                md_req.b        = {33'd0, ax_k};
                if (!wait_reg)
                begin
                    md_req.start = 1'b1;
                    wait_next    = 1'b1;
                end
                else if (md_rsp.done)
                begin
                    wait_next         = 1'b0;
                    a2_next[k_reg]    = md_rsp.result[61:0];
                    k_next            = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                    if (k_reg == 2'd2)
                        state_next = ST_PA;
                end
            end
            ST_PA:
            begin
                md_req.mul_only = 1'b1;
                md_req.a        = {32'd0, pm_reg[k_reg]};
                md_req.b        = {33'd0, ax_k};
                if (!wait_reg)
                begin
                    md_req.start = 1'b1;
                    wait_next    = 1'b1;
                end
                else if (md_rsp.done)
                begin
                    wait_next      = 1'b0;
                    pa_next[k_reg] = md_rsp.result[61:0];
                    k_next         = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                    if (k_reg == 2'd2)
                        state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                l0_next = l1_reg;
                k_next  = '0;
                if (change <= {32'd0, tol_reg} || it_reg >= max_iter_reg)
                begin
                    dsum_next  = '0;
                    np_next    = '0;
                    ny_next    = '0;
                    state_next = ST_Y;
                end
                else
                begin
                    it_next    = it_reg + 6'd1;
                    gsum_next  = '0;
                    hsum_next  = '0;
                    state_next = ST_R;
                end
            end
            ST_R:
            begin
                md_req.a = {2'b00, pa_reg[k_reg]};
                md_req.b = ONE_Q32;
                md_req.c = dm_k;
                if (!wait_reg)
                begin
                    md_req.start = 1'b1;
                    wait_next    = 1'b1;
                end
                else if (md_rsp.done)
                begin
                    wait_next  = 1'b0;
                    r_next     = md_rsp.result;
                    state_next = ST_G;
                end
            end
            ST_G:
            begin
                md_req.a = r_reg;
                md_req.b = r_reg;
                md_req.c = ONE_Q32;
                if (!wait_reg)
                begin
                    md_req.start = 1'b1;
                    wait_next    = 1'b1;
                end
                else if (md_rsp.done)
                begin
                    wait_next  = 1'b0;
                    g_next     = h_cap[61:0];
                    gsum_next  = gsum_reg + h_cap;
                    state_next = ST_H;
                end
            end
            ST_H:
            begin
                md_req.a = {2'b00, g_reg};
                md_req.b = SCALE_48;
                md_req.c = dm_k;
                if (!wait_reg)
                begin
                    md_req.start = 1'b1;
                    wait_next    = 1'b1;
                end
                else if (md_rsp.done)
                begin
                    wait_next = 1'b0;
                    hsum_next = d_k[63] ? hsum_reg - $signed(h_cap)
                                        : hsum_reg + $signed(h_cap);
                    k_next    = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                    state_next = (k_reg == 2'd2) ? ST_STEP : ST_R;
                end
            end
            ST_STEP:
            begin
                md_req.a = fm;
                md_req.b = SCALE_55;
                md_req.c = hm;
                if (!wait_reg)
                begin
                    md_req.start = 1'b1;
                    wait_next    = 1'b1;
                end
                else if (md_rsp.done)
                begin
                    wait_next  = 1'b0;
                    l1_next    = ovf ? (delta[63] ? S64_MIN : S64_MAX) : lsum;
                    state_next = ST_CHECK;
                end
            end
            ST_Y:
            begin
                md_req.a = {32'd0, pm_reg[k_reg]};
                md_req.b = {2'b00, a2_reg[k_reg]};
                md_req.c = dm_k;
                if (!wait_reg)
                begin
                    md_req.start = 1'b1;
                    wait_next    = 1'b1;
                end
                else if (md_rsp.done)
                begin
                    wait_next = 1'b0;
                    if (!neg)
                        y_next[k_reg] = (ym > 64'h7fff_ffff) ? 32'sh7fff_ffff
                                                             : $signed(ym[31:0]);
                    else
                        y_next[k_reg] = (ym >= 64'h8000_0000) ? 32'sh8000_0000
                                                              : $signed(-ym[31:0]);
                    k_next     = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                    if (k_reg == 2'd2)
                        state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                md_req.mul_only = 1'b1;
                md_req.a        = {31'd0, dmag};
                md_req.b        = {31'd0, dmag};
                if (!wait_reg)
                begin
                    md_req.start = 1'b1;
                    wait_next    = 1'b1;
                end
                else if (md_rsp.done)
                begin
                    wait_next  = 1'b0;
                    dsum_next  = dsum65[64] ? '1 : dsum65[63:0];
                    state_next = ST_NP;
                end
            end
            ST_NP:
            begin
                md_req.mul_only = 1'b1;
                md_req.a        = {32'd0, pm_reg[k_reg]};
                md_req.b        = {32'd0, pm_reg[k_reg]};
                if (!wait_reg)
                begin
                    md_req.start = 1'b1;
                    wait_next    = 1'b1;
                end
                else if (md_rsp.done)
                begin
                    wait_next  = 1'b0;
                    np_next    = np_reg + md_rsp.result;
                    state_next = ST_NY;
                end
            end
            ST_NY:
            begin
                md_req.mul_only = 1'b1;
                md_req.a        = {32'd0, ymag};
                md_req.b        = {32'd0, ymag};
                if (!wait_reg)
                begin
                    md_req.start = 1'b1;
                    wait_next    = 1'b1;
                end
                else if (md_rsp.done)
                begin
                    wait_next = 1'b0;
                    ny_next   = ny_reg + md_rsp.result;
                    k_next    = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                    if (k_reg == 2'd2)
                    begin
                        sqv_next   = dsum_reg;
                        sqr_next   = '0;
                        sqj_next   = '1;
                        state_next = ST_SQRT;
                    end
                    else
                    begin
                        state_next = ST_SQ;
                    end
                end
            end
            ST_SQRT:
            begin
                // one result bit per cycle, top pair first
                if (sqv_reg >= trial)
                begin
                    sqv_next = sqv_reg - trial;
                    sqr_next = (sqr_reg >> 1) + bitv;
                end
                else
                begin
                    sqr_next = sqr_reg >> 1;
                end
                sqj_next = sqj_reg - 5'd1;
                if (sqj_reg == '0)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // load only once the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next.closest_x       = y_reg[0];
                    out_data_next.closest_y       = y_reg[1];
                    out_data_next.closest_z       = y_reg[2];
                    out_data_next.signed_distance = (np_reg > ny_reg) ? $signed(dist_sat)
                                                                      : $signed(-dist_sat);
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `EDLN_ASSERT_IMPL(a_md_start_idle, md_req.start, !md_rsp.busy, "muldiv started while busy")
    `EDLN_ASSERT_NEXT(a_step_to_check, state_reg == ST_STEP && md_rsp.done, state_reg == ST_CHECK, "step did not return to check")
    `EDLN_ASSERT_NEXT(a_out_hold, state_reg == ST_OUT && out_valid_reg && out_stall, state_reg == ST_OUT, "result loaded over pending transaction")
    `EDLN_ASSERT_IMPL(a_sqrt_range, state_reg == ST_OUT, sqr_reg[63:32] == '0, "square root out of range")

endmodule

`default_nettype wire
